// ----- rtl/core/scvt_pkg.sv -----
// Shared types, constant tables and curve helpers for the sRGB pixel converter.
`default_nettype none

package scvt_pkg;

  // Fixed point used while building the curve tables: one = 2^44.
  localparam int unsigned FracBits = 44;
  localparam logic [63:0] FixOne = 64'd1 << FracBits;
  localparam logic [63:0] HalfMask = (64'd1 << 22) - 64'd1;
  // Scale that turns a fixed-point encode value times 1000 back into a byte.
  localparam logic [63:0] EncByteDiv = 64'd1000 * FixOne;

  // Pixel modes.
  localparam logic [1:0] MODE_UNPACK = 2'd0;
  localparam logic [1:0] MODE_PACK = 2'd1;
  localparam logic [1:0] MODE_RGB565 = 2'd2;

  // Configuration register byte addresses.
  localparam int unsigned PaddrWidth = 3;
  localparam logic [PaddrWidth-1:0] ADDR_SRGB_ENABLE = 3'd0;

  // Input and result payloads.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] packed_pixel;
    logic [15:0] lin_red;
    logic [15:0] lin_green;
    logic [15:0] lin_blue;
    logic [15:0] lin_alpha;
  } pixel_in_t;

  typedef struct packed {
    logic [31:0] packed_result;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
  } pixel_out_t;

  // Item state carried down the search pipeline; channel 0 is red, 3 is alpha.
  typedef struct packed {
    logic [1:0]       mode;
    logic [3:0]       curve;
    logic [31:0]      px;
    logic [3:0][15:0] lin;
    logic [3:0][7:0]  idx;
  } pipe_t;

  typedef logic [255:0][16:0] thr_tab_t;
  typedef logic [255:0][15:0] dec_tab_t;

  // Exact floor of (a * b) >> 44 for operands up to one.
  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, mid;
    ah = a >> 22;
    al = a & HalfMask;
    bh = b >> 22;
    bl = b & HalfMask;
    mid = ah * bl + al * bh + ((al * bl) >> 22);
    return ah * bh + (mid >> 22);
  endfunction

  function automatic logic [63:0] fx_pow5(input logic [63:0] r);
    logic [63:0] r2;
    r2 = fx_mul(r, r);
    return fx_mul(fx_mul(r2, r2), r);
  endfunction

  function automatic logic [63:0] fx_pow12(input logic [63:0] r);
    logic [63:0] r2, r4, r8;
    r2 = fx_mul(r, r);
    r4 = fx_mul(r2, r2);
    r8 = fx_mul(r4, r4);
    return fx_mul(r8, r4);
  endfunction

  // Largest r in [0, one] whose fifth or twelfth power stays at or below target.
  function automatic logic [63:0] fx_root(input logic [63:0] target, input logic twelfth);
    logic [63:0] lo, hi, mid, p;
    lo = 64'd0;
    hi = FixOne;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 64'd1) >> 1);
      p = twelfth ? fx_pow12(mid) : fx_pow5(mid);
      if (p <= target) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // sRGB decode of one byte into a 16-bit linear fraction.
  function automatic logic [15:0] decode_channel(input logic [63:0] b);
    logic [63:0] t, t2, y, v;
    if (b <= 64'd10) begin
      return 16'((64'd51400 * b + 64'd1292) / 64'd2584);
    end
    t = ((64'd1000 * b + 64'd14025) << FracBits) / 64'd269025;
    t2 = fx_mul(t, t);
    y = fx_mul(t2, fx_root(t2, 1'b0));
    v = (64'd65535 * y + (FixOne >> 1)) >> FracBits;
    return (v > 64'd65535) ? 16'hFFFF : 16'(v);
  endfunction

  // sRGB encode of one 16-bit linear fraction into a byte.
  function automatic logic [63:0] encode_channel(input logic [63:0] lin);
    logic [63:0] x, r, v, num, sub, q;
    if (lin <= 64'd205) begin
      return (64'd646 * lin + 64'd6425) / 64'd12850;
    end
    x = (lin << FracBits) / 64'd65535;
    r = fx_root(x, 1'b1);
    v = fx_mul(fx_mul(fx_mul(r, r), fx_mul(r, r)), r);
    num = 64'd269025 * v;
    sub = 64'd14025 << FracBits;
    if (num <= sub) begin
      return 64'd0;
    end
    q = (num - sub + 64'd500 * FixOne) / EncByteDiv;
    return (q > 64'd255) ? 64'd255 : q;
  endfunction

  // Smallest linear input whose encoded byte reaches each code; 65536 if none.
  function automatic thr_tab_t build_enc_thr();
    thr_tab_t tab;
    logic [63:0] lo, hi, mid;
    tab = '0;
    lo = 64'd0;
    for (int q = 1; q < 256; q++) begin
      hi = 64'd65536;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (encode_channel(mid) >= 64'(q)) begin
          hi = mid;
        end else begin
          lo = mid + 64'd1;
        end
      end
      tab[q] = 17'(lo);
    end
    return tab;
  endfunction

  // Round-to-nearest byte thresholds: code q starts at 257*q - 128.
  function automatic thr_tab_t build_plain_thr();
    thr_tab_t tab;
    tab = '0;
    for (int q = 1; q < 256; q++) begin
      tab[q] = 17'(257 * q - 128);
    end
    return tab;
  endfunction

  function automatic dec_tab_t build_dec_tab();
    dec_tab_t tab;
    for (int b = 0; b < 256; b++) begin
      tab[b] = decode_channel(64'(b));
    end
    return tab;
  endfunction

  localparam thr_tab_t ENC_THR = build_enc_thr();
  localparam thr_tab_t PLAIN_THR = build_plain_thr();
  localparam dec_tab_t DEC_TAB = build_dec_tab();

endpackage

`default_nettype wire

// ----- rtl/core/srgb_rgba8_pixel_converter_top.sv -----
// An input passes four registered search stages, each resolving two bits of every byte.
// Throughput: one pixel per cycle while the output is not stalled.
// Each stage holds its item until the next stage frees, so a stall loses nothing.
// Reset (synchronous, active high) empties the pipeline and clears srgb_enable.
// The sRGB decode curve is a 256-entry table read at the last stage.
// Top level of the sRGB / RGBA8 pixel converter.
`default_nettype none

module srgb_rgba8_pixel_converter_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire scvt_pkg::pixel_in_t             in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output scvt_pkg::pixel_out_t                 out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [scvt_pkg::PaddrWidth-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);

  localparam int unsigned NumStages = 4;

  logic                             srgb_enable;
  logic            [NumStages:0]    st_valid;
  logic            [NumStages:0]    st_ready;
  scvt_pkg::pipe_t [NumStages:0]    st_data;
  scvt_pkg::pipe_t                  last;

  scvt_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .srgb_enable (srgb_enable)
  );

  // Pipeline entry: curve flags are sampled with the transaction; alpha never uses the curve.
  assign st_data[0] = {in_data.mode,
                       {1'b0, {3{srgb_enable}}},
                       in_data.packed_pixel,
                       {in_data.lin_alpha, in_data.lin_blue, in_data.lin_green, in_data.lin_red},
                       32'd0};
  assign st_valid[0] = in_valid;
  assign in_ready = st_ready[0];

  // Search stages, most significant bit pair first.
  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    scvt_search_stage #(
      .STEP_HI (7 - 2 * g)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[g]),
      .in_ready  (st_ready[g]),
      .in_data   (st_data[g]),
      .out_valid (st_valid[g+1]),
      .out_ready (st_ready[g+1]),
      .out_data  (st_data[g+1])
    );
  end

  assign last = st_data[NumStages];
  assign out_valid = st_valid[NumStages];
  assign st_ready[NumStages] = out_ready;

  // Result formatting by mode.
  always_comb begin
    logic [7:0] b;
    out_data = '0;
    unique case (last.mode)
      scvt_pkg::MODE_UNPACK: begin
        b = last.px[7:0];
        out_data.out_red = last.curve[0] ? scvt_pkg::DEC_TAB[b] : {b, b};
        b = last.px[15:8];
        out_data.out_green = last.curve[1] ? scvt_pkg::DEC_TAB[b] : {b, b};
        b = last.px[23:16];
        out_data.out_blue = last.curve[2] ? scvt_pkg::DEC_TAB[b] : {b, b};
        out_data.out_alpha = {last.px[31:24], last.px[31:24]};
      end
      scvt_pkg::MODE_PACK: begin
        b = 8'd0;
        out_data.packed_result = {last.idx[3], last.idx[2], last.idx[1], last.idx[0]};
      end
      scvt_pkg::MODE_RGB565: begin
        b = 8'd0;
        out_data.packed_result = {8'hFF, last.px[4:0], 3'd0, last.px[10:5], 2'd0,
                                  last.px[15:11], 3'd0};
      end
      default: begin
        b = 8'd0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/scvt_cfg_regs.sv -----
// APB configuration register holding the sRGB curve enable.
`default_nettype none

module scvt_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [scvt_pkg::PaddrWidth-1:0]  paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  output logic                                  srgb_enable
);

  logic reg_hit;

  // Only one register; the word address selects it.
  assign reg_hit = (paddr[scvt_pkg::PaddrWidth-1:2] ==
                    scvt_pkg::ADDR_SRGB_ENABLE[scvt_pkg::PaddrWidth-1:2]);
  assign pready = 1'b1;

  // Register write on the access phase of a write transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      srgb_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      srgb_enable <= pwdata[0];
    end
  end

  // Read data.
  assign prdata = reg_hit ? {31'd0, srgb_enable} : 32'd0;

endmodule

`default_nettype wire

// ----- rtl/core/scvt_search_stage.sv -----
// One pipeline stage resolving two bits of each channel's output byte by threshold search.
`default_nettype none

module scvt_search_stage #(
  parameter int unsigned STEP_HI = 7
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire scvt_pkg::pipe_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output scvt_pkg::pipe_t      out_data
);

  scvt_pkg::pipe_t stage_next;

  // Two binary search steps per channel against the selected threshold table.
  always_comb begin
    logic [7:0]  idx;
    logic [7:0]  cand;
    logic [16:0] thr;
    stage_next = in_data;
    for (int ch = 0; ch < 4; ch++) begin
      idx = in_data.idx[ch];
      for (int s = 0; s < 2; s++) begin
        cand = idx | (8'd1 << (STEP_HI - s));
        thr = in_data.curve[ch] ? scvt_pkg::ENC_THR[cand] : scvt_pkg::PLAIN_THR[cand];
        if ({1'b0, in_data.lin[ch]} >= thr) begin
          idx = cand;
        end
      end
      stage_next.idx[ch] = idx;
    end
  end

  // The stage takes a new transaction when empty or when its content moves on.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= stage_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/scvt_checker.sv -----
// Port-level checks for the pixel converter, bound to its top level.
`default_nettype none

module scvt_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire scvt_pkg::pixel_out_t            out_data,
  input wire logic                            pready
);

  // A result held back by the consumer stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // A result carries either a packed word or linear channels, never both.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.packed_result == 32'd0) ||
                  ((out_data.out_red == 16'd0) && (out_data.out_green == 16'd0) &&
                   (out_data.out_blue == 16'd0) && (out_data.out_alpha == 16'd0)))
    else $error("packed and linear fields both set");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("configuration port stalled");

endmodule

bind srgb_rgba8_pixel_converter_top scvt_checker u_scvt_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);

`default_nettype wire
